// ----- rtl/wwg_pkg.sv -----
`default_nettype none

package wwg_pkg;

	typedef enum logic [1:0] {
		CELL_EMPTY     = 2'd0,
		CELL_CONDUCTOR = 2'd1,
		CELL_HEAD      = 2'd2,
		CELL_TAIL      = 2'd3
	} cell_t;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_EDIT  = 2'd1,
		ACT_STEP  = 2'd2,
		ACT_SPARE = 2'd3
	} action_t;

	typedef enum logic {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} reg_index_t;

	// edit order: empty -> conductor -> head -> tail -> empty
	function automatic cell_t next_in_cycle(input cell_t c);
		cell_t n;
		unique case (c)
			CELL_EMPTY:     n = CELL_CONDUCTOR;
			CELL_CONDUCTOR: n = CELL_HEAD;
			CELL_HEAD:      n = CELL_TAIL;
			CELL_TAIL:      n = CELL_EMPTY;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/wireworld_grid_engine.sv -----
`default_nettype none

// Wireworld grid engine. Holds a MAX_ROWS by MAX_COLS grid of 2-bit cells
// (0 empty, 1 conductor, 2 head, 3 tail) in one block memory; only the top-left
// rows_in_use by cols_in_use cells take part, sizes above the parameters act as
// the parameters. Each item carries one action: read a cell, edit a cell (step
// it through empty, conductor, head, tail) or advance one generation. Every
// item returns exactly one result: the addressed cell after the action, or 0
// with address_error set when the address lies outside the sizes in use (a
// generation step still runs then). After reset the block sweeps the whole memory
// to empty and takes no item meanwhile; configuration writes are taken at any
// time. The grid memory has one read port, so the 3 by 3 window is filled one
// column at a time, reading the row above, the own row and the row below, and
// the shared rule unit evaluates one cell per column; the new generation is
// then copied back one cell per cycle from a scratch memory. The block takes one
// item at a time; in_ready is high only while it is idle, and a finished
// result waits in the output register without blocking the next acceptance.
module wireworld_grid_engine #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,

	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [6:0] cfg_data,

	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] action,
	input  wire logic [5:0] cell_row,
	input  wire logic [5:0] cell_col,

	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      cell_state,
	output logic            address_error
);

	localparam int RW      = $clog2(MAX_ROWS);
	localparam int CW      = $clog2(MAX_COLS);
	localparam int AW      = RW + CW;
	localparam int ROW_CAP = (MAX_ROWS < 127) ? MAX_ROWS : 127;
	localparam int COL_CAP = (MAX_COLS < 127) ? MAX_COLS : 127;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP,
		ST_COPY,
		ST_DRAIN,
		ST_RD,
		ST_RDW,
		ST_OUT
	} state_t;

	// cell (r, c) lives at {r, c}; rows and columns stay below the parameters
	function automatic logic [AW-1:0] cell_addr(input logic [6:0] r, input logic [6:0] c);
		return {RW'(r), CW'(c)};
	endfunction

	state_t                 state_q;
	logic [AW-1:0]          clr_q;
	logic [6:0]             rows_in_use_q;
	logic [6:0]             cols_in_use_q;
	logic [6:0]             r_q;
	logic [7:0]             x_q;
	logic [1:0]             k_q;
	logic                   cp_valid_q;
	logic [AW-1:0]          cp_addr_q;
	logic                   out_valid_q;
	wwg_pkg::cell_t         cell_state_q;
	logic                   address_error_q;

	wwg_pkg::action_t       act_q;
	logic                   bad_q;
	logic [AW-1:0]          idx_q;
	wwg_pkg::cell_t         res_q;
	wwg_pkg::cell_t         top_q;
	wwg_pkg::cell_t         mid_q;
	wwg_pkg::cell_t         win_q [3][3];

	logic [6:0]             eff_rows;
	logic [6:0]             eff_cols;
	logic [6:0]             r_up;
	logic [6:0]             r_dn;
	logic                   col_ok;
	logic                   top_ok;
	logic                   bot_ok;
	logic                   row_end;
	logic                   eval_now;
	logic                   accept;
	logic                   in_bad;

	logic                   grid_we;
	logic [AW-1:0]          grid_waddr;
	wwg_pkg::cell_t         grid_wdata;
	logic [AW-1:0]          grid_raddr;
	wwg_pkg::cell_t         grid_rdata;
	logic [AW-1:0]          sweep_raddr;
	logic [AW-1:0]          copy_raddr;
	wwg_pkg::cell_t         next_rdata;
	wwg_pkg::cell_t         rule_next;
	logic [7:0]             neigh_heads;

	// clamp the size registers to the grid that is built
	assign eff_rows = (rows_in_use_q > 7'(ROW_CAP)) ? 7'(ROW_CAP) : rows_in_use_q;
	assign eff_cols = (cols_in_use_q > 7'(COL_CAP)) ? 7'(COL_CAP) : cols_in_use_q;

	assign r_up     = r_q - 7'd1;
	assign r_dn     = r_q + 7'd1;
	assign col_ok   = x_q < {1'b0, eff_cols};
	assign top_ok   = (r_q != 7'd0) && col_ok;
	assign bot_ok   = (r_dn < eff_rows) && col_ok;
	assign row_end  = (x_q == ({1'b0, eff_cols} + 8'd1));
	// window center sits two columns behind the read pointer
	assign eval_now = (state_q == ST_SWEEP) && (k_q == 2'd0) && (x_q >= 8'd2);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_bad   = ({1'b0, cell_row} >= eff_rows) || ({1'b0, cell_col} >= eff_cols);

	assign out_valid     = out_valid_q;
	assign cell_state    = cell_state_q;
	assign address_error = address_error_q;

	// window read order per column: row above, own row, row below
	always_comb begin
		unique case (k_q)
			2'd0:    sweep_raddr = cell_addr(r_up, x_q[6:0]);
			2'd1:    sweep_raddr = cell_addr(r_q, x_q[6:0]);
			2'd2:    sweep_raddr = cell_addr(r_dn, x_q[6:0]);
			default: sweep_raddr = cell_addr(r_q, x_q[6:0]);
		endcase
	end

	assign copy_raddr = cell_addr(r_q, x_q[6:0]);
	assign grid_raddr = (state_q == ST_SWEEP) ? sweep_raddr : idx_q;

	// grid write port: clearing pass, copy-back, edit
	always_comb begin
		grid_we    = 1'b0;
		grid_waddr = idx_q;
		grid_wdata = wwg_pkg::CELL_EMPTY;
		priority if (state_q == ST_CLEAR) begin
			grid_we    = 1'b1;
			grid_waddr = clr_q;
			grid_wdata = wwg_pkg::CELL_EMPTY;
		end else if (cp_valid_q) begin
			grid_we    = 1'b1;
			grid_waddr = cp_addr_q;
			grid_wdata = next_rdata;
		end else if (state_q == ST_RDW && act_q == wwg_pkg::ACT_EDIT && !bad_q) begin
			grid_we    = 1'b1;
			grid_wdata = wwg_pkg::next_in_cycle(grid_rdata);
		end else begin
			grid_we    = 1'b0;
		end
	end

	// head flags of the eight neighbors around the window center
	assign neigh_heads = {
		win_q[0][0] == wwg_pkg::CELL_HEAD, win_q[0][1] == wwg_pkg::CELL_HEAD,
		win_q[0][2] == wwg_pkg::CELL_HEAD, win_q[1][0] == wwg_pkg::CELL_HEAD,
		win_q[1][2] == wwg_pkg::CELL_HEAD, win_q[2][0] == wwg_pkg::CELL_HEAD,
		win_q[2][1] == wwg_pkg::CELL_HEAD, win_q[2][2] == wwg_pkg::CELL_HEAD
	};

	wwg_grid_mem #(.AW(AW)) u_grid (
		.clk   (clk),
		.we    (grid_we),
		.waddr (grid_waddr),
		.wdata (grid_wdata),
		.raddr (grid_raddr),
		.rdata (grid_rdata)
	);

	wwg_grid_mem #(.AW(AW)) u_next (
		.clk   (clk),
		.we    (eval_now),
		.waddr (cell_addr(r_q, 7'(x_q - 8'd2))),
		.wdata (rule_next),
		.raddr (copy_raddr),
		.rdata (next_rdata)
	);

	wwg_cell_rule u_rule (
		.center      (win_q[1][1]),
		.neigh_heads (neigh_heads),
		.next_cell   (rule_next)
	);

	// sequencer, size registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			clr_q           <= '0;
			rows_in_use_q   <= 7'd64;
			cols_in_use_q   <= 7'd64;
			r_q             <= '0;
			x_q             <= '0;
			k_q             <= '0;
			cp_valid_q      <= 1'b0;
			cp_addr_q       <= '0;
			out_valid_q     <= 1'b0;
			cell_state_q    <= wwg_pkg::CELL_EMPTY;
			address_error_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (wwg_pkg::reg_index_t'(cfg_index))
					wwg_pkg::REG_ROWS: rows_in_use_q <= cfg_data;
					wwg_pkg::REG_COLS: cols_in_use_q <= cfg_data;
				endcase
			end

			// drop the result once taken
			if (out_valid_q && out_ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end

			cp_valid_q <= (state_q == ST_COPY);
			if (state_q == ST_COPY) begin
				cp_addr_q <= copy_raddr;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {AW{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (action == wwg_pkg::ACT_STEP && eff_rows != 7'd0 && eff_cols != 7'd0) begin
							state_q <= ST_SWEEP;
							r_q     <= '0;
							x_q     <= '0;
							k_q     <= '0;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_SWEEP: begin
					unique case (k_q)
						2'd0: begin
							if (row_end) begin
								x_q <= '0;
								if (r_dn == eff_rows) begin
									r_q     <= '0;
									state_q <= ST_COPY;
								end else begin
									r_q <= r_dn;
								end
							end else begin
								k_q <= 2'd1;
							end
						end
						2'd1: k_q <= 2'd2;
						2'd2: k_q <= 2'd3;
						2'd3: begin
							k_q <= 2'd0;
							x_q <= x_q + 8'd1;
						end
					endcase
				end
				ST_COPY: begin
					if ((x_q[6:0] + 7'd1) == eff_cols) begin
						x_q <= '0;
						if (r_dn == eff_rows) begin
							state_q <= ST_DRAIN;
						end else begin
							r_q <= r_dn;
						end
					end else begin
						x_q <= x_q + 8'd1;
					end
				end
				ST_DRAIN: state_q <= ST_RD;
				ST_RD:    state_q <= ST_RDW;
				ST_RDW:   state_q <= ST_OUT;
				ST_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q     <= 1'b1;
						cell_state_q    <= res_q;
						address_error_q <= bad_q;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers: latched item, result, 3 by 3 window
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= wwg_pkg::action_t'(action);
			bad_q <= in_bad;
			idx_q <= cell_addr({1'b0, cell_row}, {1'b0, cell_col});
		end

		if (state_q == ST_RDW) begin
			if (bad_q) begin
				res_q <= wwg_pkg::CELL_EMPTY;
			end else if (act_q == wwg_pkg::ACT_EDIT) begin
				res_q <= wwg_pkg::next_in_cycle(grid_rdata);
			end else begin
				res_q <= grid_rdata;
			end
		end

		// clear the window at the start of every row
		if ((accept) || (state_q == ST_SWEEP && k_q == 2'd0 && row_end)) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= wwg_pkg::CELL_EMPTY;
				end
			end
		end else if (state_q == ST_SWEEP) begin
			unique case (k_q)
				2'd1: top_q <= top_ok ? grid_rdata : wwg_pkg::CELL_EMPTY;
				2'd2: mid_q <= col_ok ? grid_rdata : wwg_pkg::CELL_EMPTY;
				2'd3: begin
					// advance the window by one column
					for (int i = 0; i < 3; i++) begin
						win_q[i][0] <= win_q[i][1];
						win_q[i][1] <= win_q[i][2];
					end
					win_q[0][2] <= top_q;
					win_q[1][2] <= mid_q;
					win_q[2][2] <= bot_ok ? grid_rdata : wwg_pkg::CELL_EMPTY;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/wwg_grid_mem.sv -----
`default_nettype none

module wwg_grid_mem #(
	parameter int AW = 12
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire wwg_pkg::cell_t   wdata,
	input  wire logic [AW-1:0]    raddr,
	output wwg_pkg::cell_t        rdata
);

	localparam int DEPTH = 1 << AW;

	wwg_pkg::cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/wwg_cell_rule.sv -----
`default_nettype none

module wwg_cell_rule (
	input  wire wwg_pkg::cell_t  center,
	input  wire logic [7:0]      neigh_heads,
	output wwg_pkg::cell_t       next_cell
);

	logic [3:0] heads;

	assign heads = 4'($countones(neigh_heads));

	always_comb begin
		unique case (center)
			wwg_pkg::CELL_EMPTY:     next_cell = wwg_pkg::CELL_EMPTY;
			wwg_pkg::CELL_HEAD:      next_cell = wwg_pkg::CELL_TAIL;
			wwg_pkg::CELL_TAIL:      next_cell = wwg_pkg::CELL_CONDUCTOR;
			wwg_pkg::CELL_CONDUCTOR: begin
				// fire on one or two head neighbors
				if (heads == 4'd1 || heads == 4'd2) begin
					next_cell = wwg_pkg::CELL_HEAD;
				end else begin
					next_cell = wwg_pkg::CELL_CONDUCTOR;
				end
			end
		endcase
	end

endmodule

`default_nettype wire
